// File: rtl/core/ccem_pkg.sv
// Shared codes, field limits and widths for the clock and calendar block.
`default_nettype none

package ccem_pkg;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_ENCODER = 2'd1;
   localparam logic [1:0] OP_REFRESH = 2'd2;

   localparam logic [1:0] MODE_MENU = 2'd0;
   localparam logic [1:0] MODE_TIME = 2'd1;
   localparam logic [1:0] MODE_DATE = 2'd2;

   localparam logic [1:0] TURN_CW   = 2'd0;
   localparam logic [1:0] TURN_CCW  = 2'd1;
   localparam logic [1:0] TURN_NONE = 2'd2;

   localparam logic [1:0] TIME_HOUR   = 2'd0;
   localparam logic [1:0] TIME_MINUTE = 2'd1;
   localparam logic [1:0] TIME_SECOND = 2'd2;
   localparam logic [1:0] TIME_AMPM   = 2'd3;

   localparam logic [1:0] DATE_MONTH = 2'd0;
   localparam logic [1:0] DATE_DAY   = 2'd1;
   localparam logic [1:0] DATE_YEAR  = 2'd2;

   localparam int FIELD_WIDTH = 12;

   localparam logic [11:0] SEC_LIMIT   = 12'd60;
   localparam logic [11:0] HOUR_LIMIT  = 12'd13;
   localparam logic [11:0] HOUR_NOON   = 12'd12;
   localparam logic [11:0] DAY_LIMIT   = 12'd32;
   localparam logic [11:0] MONTH_LIMIT = 12'd13;
   localparam logic [11:0] YEAR_BASE   = 12'd2000;
   localparam logic [11:0] YEAR_LOW    = 12'd2001;
   localparam logic [11:0] YEAR_HIGH   = 12'd2100;
   localparam logic [11:0] MIN_SEC_MAX = 12'd59;
   localparam logic [11:0] HOUR_MAX    = 12'd12;
   localparam logic [11:0] MONTH_MAX   = 12'd12;
   localparam logic [11:0] DAY_MAX     = 12'd31;

   typedef struct packed {
      logic [11:0] value;
      logic [11:0] low;
      logic [11:0] high;
   } move_sel_type;

endpackage

`default_nettype wire

// File: rtl/core/clock_calendar_with_encoder_menu.sv
// Twelve-hour clock and calendar with an encoder-driven set-up menu.
// A request is held in the input register until its result is loaded into the state registers.
// Throughput: one transaction per cycle; the input register and the state update
// form a two-stage pipeline that advances whenever the result is free or taken.
// Reset: synchronous and active high; the clock starts at 12:00:00 PM, 1/1/2000,
// in the menu with the step counter cleared and no result pending.
`default_nettype none

module clock_calendar_with_encoder_menu #(
   parameter int STEP_COUNT_WIDTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic        req_encoder_clk,
   input  wire logic        req_encoder_dt,
   input  wire logic        req_button,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_hour_now,
   output logic [5:0]       rsp_minute_now,
   output logic [5:0]       rsp_second_now,
   output logic             rsp_is_pm,
   output logic [3:0]       rsp_month_now,
   output logic [4:0]       rsp_day_now,
   output logic [11:0]      rsp_year_now,
   output logic [1:0]       rsp_mode,
   output logic             rsp_menu_choice,
   output logic [1:0]       rsp_field_choice,
   output logic [1:0]       rsp_turn
);

   localparam int SW = STEP_COUNT_WIDTH;
   localparam int CW = ((SW > ccem_pkg::FIELD_WIDTH) ? SW : ccem_pkg::FIELD_WIDTH) + 2;
   localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

   function automatic logic [11:0] circ_move(input logic signed [SW-1:0] delta,
                                             input logic [11:0] value,
                                             input logic [11:0] low,
                                             input logic [11:0] high);
      logic signed [CW-1:0] sum;
      logic signed [CW-1:0] lo_s;
      logic signed [CW-1:0] hi_s;
      logic [11:0]          res;
      sum  = $signed({{(CW-12){1'b0}}, value}) + CW'(delta);
      lo_s = $signed({{(CW-12){1'b0}}, low});
      hi_s = $signed({{(CW-12){1'b0}}, high});
      if (delta > 0) begin
         res = (sum > hi_s) ? low : sum[11:0];
      end else if (delta < 0) begin
         res = (sum < lo_s) ? high : sum[11:0];
      end else begin
         res = value;
      end
      return res;
   endfunction

   logic                   in_vld_ff;
   logic [1:0]             op_ff;
   logic                   enc_clk_ff;
   logic                   enc_dt_ff;
   logic                   button_ff;
   logic                   rsp_vld_ff;
   logic                   advance;
   logic                   fire;

   logic [1:0]             mode_ff, mode_in;
   logic                   menu_pos_ff, menu_pos_in;
   logic [1:0]             time_pos_ff, time_pos_in;
   logic [1:0]             date_pos_ff, date_pos_in;
   logic [3:0]             hours_ff, hours_in;
   logic [5:0]             minutes_ff, minutes_in;
   logic [5:0]             seconds_ff, seconds_in;
   logic                   pm_ff, pm_in;
   logic [4:0]             days_ff, days_in;
   logic [3:0]             months_ff, months_in;
   logic [11:0]            years_ff, years_in;
   logic signed [SW-1:0]   step_ff, step_in;
   logic                   last_clk_ff, last_clk_in;
   logic [1:0]             turn_ff, turn_in;

   ccem_pkg::move_sel_type mv_sel;
   logic [11:0]            mv_res;
   logic [11:0]            menu_res;

   logic [11:0]            t_sec;
   logic [11:0]            t_min;
   logic [11:0]            t_hr;
   logic                   t_pm;
   logic [11:0]            t_day;
   logic [11:0]            t_mon;
   logic [11:0]            t_yr;

   assign advance   = !rsp_vld_ff || rsp_ready;
   assign fire      = in_vld_ff && advance;
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff      <= req_op;
         enc_clk_ff <= req_encoder_clk;
         enc_dt_ff  <= req_encoder_dt;
         button_ff  <= req_button;
      end
   end

   always_comb begin
      mv_sel = '{value: 12'd0, low: 12'd0, high: 12'd0};
      if (mode_ff == ccem_pkg::MODE_TIME) begin
         unique case (time_pos_ff)
            ccem_pkg::TIME_HOUR:
               mv_sel = '{value: {8'd0, hours_ff}, low: 12'd1, high: ccem_pkg::HOUR_MAX};
            ccem_pkg::TIME_MINUTE:
               mv_sel = '{value: {6'd0, minutes_ff}, low: 12'd0,
                          high: ccem_pkg::MIN_SEC_MAX};
            ccem_pkg::TIME_SECOND:
               mv_sel = '{value: {6'd0, seconds_ff}, low: 12'd0,
                          high: ccem_pkg::MIN_SEC_MAX};
            default:
               mv_sel = '{value: {11'd0, pm_ff}, low: 12'd0, high: 12'd1};
         endcase
      end else begin
         unique case (date_pos_ff)
            ccem_pkg::DATE_MONTH:
               mv_sel = '{value: {8'd0, months_ff}, low: 12'd1, high: ccem_pkg::MONTH_MAX};
            ccem_pkg::DATE_DAY:
               mv_sel = '{value: {7'd0, days_ff}, low: 12'd1, high: ccem_pkg::DAY_MAX};
            default:
               mv_sel = '{value: years_ff, low: ccem_pkg::YEAR_LOW,
                          high: ccem_pkg::YEAR_HIGH};
         endcase
      end
   end

   assign mv_res   = circ_move(step_ff, mv_sel.value, mv_sel.low, mv_sel.high);
   assign menu_res = circ_move(step_ff, {11'd0, menu_pos_ff}, 12'd0, 12'd1);

   always_comb begin
      t_sec = {6'd0, seconds_ff} + 12'd1;
      t_min = {6'd0, minutes_ff};
      t_hr  = {8'd0, hours_ff};
      t_pm  = pm_ff;
      t_day = {7'd0, days_ff};
      t_mon = {8'd0, months_ff};
      t_yr  = years_ff;
      if (t_sec >= ccem_pkg::SEC_LIMIT) begin
         t_sec = 12'd0;
         t_min = t_min + 12'd1;
      end
      if (t_min >= ccem_pkg::SEC_LIMIT) begin
         t_min = 12'd0;
         t_hr  = t_hr + 12'd1;
         if (t_hr == ccem_pkg::HOUR_NOON) begin
            if (t_pm) begin
               t_pm  = 1'b0;
               t_day = t_day + 12'd1;
            end else begin
               t_pm = 1'b1;
            end
         end
      end
      if (t_hr >= ccem_pkg::HOUR_LIMIT) begin
         t_hr = 12'd1;
      end
      if (t_day >= ccem_pkg::DAY_LIMIT) begin
         t_mon = t_mon + 12'd1;
         t_day = 12'd1;
      end
      if (t_mon >= ccem_pkg::MONTH_LIMIT) begin
         t_yr  = t_yr + 12'd1;
         t_mon = 12'd1;
         if (t_yr > ccem_pkg::YEAR_HIGH) begin
            t_yr = ccem_pkg::YEAR_BASE;
         end
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      menu_pos_in = menu_pos_ff;
      time_pos_in = time_pos_ff;
      date_pos_in = date_pos_ff;
      hours_in    = hours_ff;
      minutes_in  = minutes_ff;
      seconds_in  = seconds_ff;
      pm_in       = pm_ff;
      days_in     = days_ff;
      months_in   = months_ff;
      years_in    = years_ff;
      step_in     = step_ff;
      last_clk_in = last_clk_ff;
      turn_in     = turn_ff;
      if (fire) begin
         turn_in = ccem_pkg::TURN_NONE;
         unique case (op_ff)
            ccem_pkg::OP_TICK: begin
               if (mode_ff != ccem_pkg::MODE_TIME) begin
                  seconds_in = t_sec[5:0];
                  minutes_in = t_min[5:0];
                  hours_in   = t_hr[3:0];
                  pm_in      = t_pm;
                  days_in    = t_day[4:0];
                  months_in  = t_mon[3:0];
                  years_in   = t_yr;
               end
            end
            ccem_pkg::OP_ENCODER: begin
               last_clk_in = enc_clk_ff;
               if (enc_clk_ff != last_clk_ff) begin
                  if (enc_dt_ff != enc_clk_ff) begin
                     turn_in = ccem_pkg::TURN_CW;
                     if (step_ff < SMAX) begin
                        step_in = step_ff + SW'(1);
                     end
                  end else begin
                     turn_in = ccem_pkg::TURN_CCW;
                     if (step_ff > SMIN) begin
                        step_in = step_ff - SW'(1);
                     end
                  end
               end
            end
            ccem_pkg::OP_REFRESH: begin
               step_in     = '0;
               menu_pos_in = menu_res[0];
               if (mode_ff == ccem_pkg::MODE_MENU) begin
                  if (button_ff) begin
                     mode_in = menu_res[0] ? ccem_pkg::MODE_DATE : ccem_pkg::MODE_TIME;
                  end
               end else if (mode_ff == ccem_pkg::MODE_TIME) begin
                  unique case (time_pos_ff)
                     ccem_pkg::TIME_HOUR:   hours_in   = mv_res[3:0];
                     ccem_pkg::TIME_MINUTE: minutes_in = mv_res[5:0];
                     ccem_pkg::TIME_SECOND: seconds_in = mv_res[5:0];
                     default:               pm_in      = mv_res[0];
                  endcase
                  if (button_ff) begin
                     if (time_pos_ff == ccem_pkg::TIME_AMPM) begin
                        time_pos_in = ccem_pkg::TIME_HOUR;
                        mode_in     = ccem_pkg::MODE_MENU;
                     end else begin
                        time_pos_in = time_pos_ff + 2'd1;
                     end
                  end
               end else if (mode_ff == ccem_pkg::MODE_DATE) begin
                  unique case (date_pos_ff)
                     ccem_pkg::DATE_MONTH: months_in = mv_res[3:0];
                     ccem_pkg::DATE_DAY:   days_in   = mv_res[4:0];
                     ccem_pkg::DATE_YEAR:  years_in  = mv_res;
                     default: ;
                  endcase
                  if (button_ff) begin
                     if (date_pos_ff >= ccem_pkg::DATE_YEAR) begin
                        date_pos_in = ccem_pkg::DATE_MONTH;
                        mode_in     = ccem_pkg::MODE_MENU;
                     end else begin
                        date_pos_in = date_pos_ff + 2'd1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         mode_ff     <= ccem_pkg::MODE_MENU;
         menu_pos_ff <= 1'b0;
         time_pos_ff <= ccem_pkg::TIME_HOUR;
         date_pos_ff <= ccem_pkg::DATE_MONTH;
         hours_ff    <= 4'd12;
         minutes_ff  <= 6'd0;
         seconds_ff  <= 6'd0;
         pm_ff       <= 1'b1;
         days_ff     <= 5'd1;
         months_ff   <= 4'd1;
         years_ff    <= ccem_pkg::YEAR_BASE;
         step_ff     <= '0;
         last_clk_ff <= 1'b0;
         turn_ff     <= ccem_pkg::TURN_NONE;
      end else begin
         if (advance) begin
            rsp_vld_ff <= in_vld_ff;
         end
         mode_ff     <= mode_in;
         menu_pos_ff <= menu_pos_in;
         time_pos_ff <= time_pos_in;
         date_pos_ff <= date_pos_in;
         hours_ff    <= hours_in;
         minutes_ff  <= minutes_in;
         seconds_ff  <= seconds_in;
         pm_ff       <= pm_in;
         days_ff     <= days_in;
         months_ff   <= months_in;
         years_ff    <= years_in;
         step_ff     <= step_in;
         last_clk_ff <= last_clk_in;
         turn_ff     <= turn_in;
      end
   end

   // The state registers only change on a transaction that also loads the
   // result, so they serve directly as the result register.
   assign rsp_valid       = rsp_vld_ff;
   assign rsp_hour_now    = hours_ff;
   assign rsp_minute_now  = minutes_ff;
   assign rsp_second_now  = seconds_ff;
   assign rsp_is_pm       = pm_ff;
   assign rsp_month_now   = months_ff;
   assign rsp_day_now     = days_ff;
   assign rsp_year_now    = years_ff;
   assign rsp_mode        = mode_ff;
   assign rsp_menu_choice = menu_pos_ff;
   assign rsp_turn        = turn_ff;
   assign rsp_field_choice = (mode_ff == ccem_pkg::MODE_TIME) ? time_pos_ff :
                             (mode_ff == ccem_pkg::MODE_DATE) ? date_pos_ff : 2'd0;

endmodule

`default_nettype wire

// File: rtl/core/ccem_checker.sv
// Port-level checker for the clock and calendar block, bound to its top level.
`default_nettype none

module ccem_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_hour_now,
   input wire logic [5:0]  rsp_minute_now,
   input wire logic [5:0]  rsp_second_now,
   input wire logic [3:0]  rsp_month_now,
   input wire logic [4:0]  rsp_day_now,
   input wire logic [11:0] rsp_year_now,
   input wire logic [1:0]  rsp_mode,
   input wire logic [1:0]  rsp_field_choice,
   input wire logic [1:0]  rsp_turn
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("Accepted transaction produced no pending result.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hour_now)
         && $stable(rsp_year_now) && $stable(rsp_turn) && $stable(rsp_field_choice))
      else $error("Stalled result changed.");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hour_now >= 4'd1 && rsp_hour_now <= 4'd12
         && rsp_minute_now <= 6'd59 && rsp_second_now <= 6'd59
         && rsp_turn != 2'd3)
      else $error("Time field out of range.");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month_now >= 4'd1 && rsp_month_now <= 4'd12
         && rsp_day_now >= 5'd1 && rsp_year_now >= 12'd2000
         && rsp_year_now <= 12'd2100 && rsp_mode != 2'd3
         && (rsp_mode != ccem_pkg::MODE_MENU || rsp_field_choice == 2'd0))
      else $error("Date field or mode out of range.");

endmodule

bind clock_calendar_with_encoder_menu ccem_checker u_ccem_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the twelve-hour clock and calendar block with its encoder menu.
`timescale 1ns / 100ps

module testbench;
   import ccem_pkg::*;

   localparam int STEP_WIDTH  = 8;
   localparam int STEP_MAX    = (1 << (STEP_WIDTH - 1)) - 1;
   localparam int STEP_MIN    = -STEP_MAX - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [3:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        pm;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [11:0] year;
      logic [1:0]  mode;
      logic        menu_line;
      logic [1:0]  field;
      logic [1:0]  turn;
   } clock_view_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = OP_TICK;
   logic        req_encoder_clk = 1'b0;
   logic        req_encoder_dt = 1'b0;
   logic        req_button = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_hour_now;
   logic [5:0]  rsp_minute_now;
   logic [5:0]  rsp_second_now;
   logic        rsp_is_pm;
   logic [3:0]  rsp_month_now;
   logic [4:0]  rsp_day_now;
   logic [11:0] rsp_year_now;
   logic [1:0]  rsp_mode;
   logic        rsp_menu_choice;
   logic [1:0]  rsp_field_choice;
   logic [1:0]  rsp_turn;

   // Predicted state of the clock, the calendar and the menu.
   logic [1:0]  mode_q = MODE_MENU;
   logic        menu_q = 1'b0;
   logic [1:0]  time_pos_q = TIME_HOUR;
   logic [1:0]  date_pos_q = DATE_MONTH;
   int          hours_q = 12;
   int          minutes_q = 0;
   int          seconds_q = 0;
   int          pm_q = 1;
   int          days_q = 1;
   int          months_q = 1;
   int          years_q = 2000;
   int          steps_q = 0;
   logic        last_clk_q = 1'b0;

   clock_view_t expected_views[$];
   int          items_sent = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          sink_wait = 0;
   int          sink_hold_cycles = 0;
   bit          source_idle_on = 1'b1;
   bit          sink_idle_on = 1'b1;

   clock_calendar_with_encoder_menu uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_encoder_clk(req_encoder_clk),
      .req_encoder_dt(req_encoder_dt),
      .req_button(req_button),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hour_now(rsp_hour_now),
      .rsp_minute_now(rsp_minute_now),
      .rsp_second_now(rsp_second_now),
      .rsp_is_pm(rsp_is_pm),
      .rsp_month_now(rsp_month_now),
      .rsp_day_now(rsp_day_now),
      .rsp_year_now(rsp_year_now),
      .rsp_mode(rsp_mode),
      .rsp_menu_choice(rsp_menu_choice),
      .rsp_field_choice(rsp_field_choice),
      .rsp_turn(rsp_turn)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int wrap_move(int delta, int value, int lo, int hi);
      int moved;
      moved = value + delta;
      if (delta > 0) return (moved > hi) ? lo : moved;
      if (delta < 0) return (moved < lo) ? hi : moved;
      return value;
   endfunction

   function automatic clock_view_t apply_transaction(logic [1:0] op, logic enc_clk,
                                                     logic enc_dt, logic btn);
      clock_view_t view;
      logic [1:0]  turn;
      int          delta;
      turn = TURN_NONE;
      case (op)
         OP_TICK: begin
            if (mode_q != MODE_TIME) begin
               seconds_q++;
               if (seconds_q >= SEC_LIMIT) begin
                  seconds_q = 0;
                  minutes_q++;
               end
               if (minutes_q >= SEC_LIMIT) begin
                  minutes_q = 0;
                  hours_q++;
                  if (hours_q == HOUR_NOON) begin
                     if (pm_q != 0) begin
                        pm_q = 0;
                        days_q++;
                     end else begin
                        pm_q = 1;
                     end
                  end
               end
               if (hours_q >= HOUR_LIMIT) hours_q = 1;
               if (days_q >= DAY_LIMIT) begin
                  months_q++;
                  days_q = 1;
               end
               if (months_q >= MONTH_LIMIT) begin
                  years_q++;
                  months_q = 1;
                  if (years_q > YEAR_HIGH) years_q = YEAR_BASE;
               end
            end
         end
         OP_ENCODER: begin
            if (enc_clk != last_clk_q) begin
               if (enc_dt != enc_clk) begin
                  if (steps_q < STEP_MAX) steps_q++;
                  turn = TURN_CW;
               end else begin
                  if (steps_q > STEP_MIN) steps_q--;
                  turn = TURN_CCW;
               end
            end
            last_clk_q = enc_clk;
         end
         OP_REFRESH: begin
            delta = steps_q;
            menu_q = wrap_move(delta, menu_q, 0, 1);
            case (mode_q)
               MODE_MENU: begin
                  if (btn) mode_q = (menu_q == 1'b0) ? MODE_TIME : MODE_DATE;
               end
               MODE_TIME: begin
                  case (time_pos_q)
                     TIME_HOUR:   hours_q = wrap_move(delta, hours_q, 1, HOUR_MAX);
                     TIME_MINUTE: minutes_q = wrap_move(delta, minutes_q, 0, MIN_SEC_MAX);
                     TIME_SECOND: seconds_q = wrap_move(delta, seconds_q, 0, MIN_SEC_MAX);
                     default:     pm_q = wrap_move(delta, pm_q, 0, 1);
                  endcase
                  if (btn) begin
                     if (time_pos_q == TIME_AMPM) begin
                        time_pos_q = TIME_HOUR;
                        mode_q = MODE_MENU;
                     end else begin
                        time_pos_q = time_pos_q + 2'd1;
                     end
                  end
               end
               MODE_DATE: begin
                  case (date_pos_q)
                     DATE_MONTH: months_q = wrap_move(delta, months_q, 1, MONTH_MAX);
                     DATE_DAY:   days_q = wrap_move(delta, days_q, 1, DAY_MAX);
                     DATE_YEAR:  years_q = wrap_move(delta, years_q, YEAR_LOW, YEAR_HIGH);
                     default:    ;
                  endcase
                  if (btn) begin
                     if (date_pos_q >= DATE_YEAR) begin
                        date_pos_q = DATE_MONTH;
                        mode_q = MODE_MENU;
                     end else begin
                        date_pos_q = date_pos_q + 2'd1;
                     end
                  end
               end
               default: ;
            endcase
            steps_q = 0;
         end
         default: ;
      endcase
      view.hour      = 4'(hours_q);
      view.minute    = 6'(minutes_q);
      view.second    = 6'(seconds_q);
      view.pm        = 1'(pm_q);
      view.month     = 4'(months_q);
      view.day       = 5'(days_q);
      view.year      = 12'(years_q);
      view.mode      = mode_q;
      view.menu_line = menu_q;
      view.field     = (mode_q == MODE_TIME) ? time_pos_q :
                       (mode_q == MODE_DATE) ? date_pos_q : 2'd0;
      view.turn      = turn;
      return view;
   endfunction

   task automatic report_mismatch(string what, logic [11:0] got, logic [11:0] want);
      if (got !== want) begin
         error_count++;
         if (error_count <= PRINT_LIMIT)
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   always @(posedge clock) begin : result_check
      clock_view_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               report_mismatch("unrequested result", 12'd1, 12'd0);
            end else begin
               want = expected_views.pop_front();
               report_mismatch("hour", rsp_hour_now, want.hour);
               report_mismatch("minute", rsp_minute_now, want.minute);
               report_mismatch("second", rsp_second_now, want.second);
               report_mismatch("pm flag", rsp_is_pm, want.pm);
               report_mismatch("month", rsp_month_now, want.month);
               report_mismatch("day", rsp_day_now, want.day);
               report_mismatch("year", rsp_year_now, want.year);
               report_mismatch("mode", rsp_mode, want.mode);
               report_mismatch("menu choice", rsp_menu_choice, want.menu_line);
               report_mismatch("field choice", rsp_field_choice, want.field);
               report_mismatch("turn", rsp_turn, want.turn);
            end
            sink_wait = sink_idle_on ? $urandom_range(0, 6) : 0;
         end
         if (sink_hold_cycles > 0) begin
            sink_hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (sink_wait > 0) begin
            if (rsp_valid) sink_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_views.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_item(logic [1:0] op, logic enc_clk, logic enc_dt, logic btn);
      int gap;
      gap = source_idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_encoder_clk <= enc_clk;
      req_encoder_dt  <= enc_dt;
      req_button      <= btn;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_views.push_back(apply_transaction(op, enc_clk, enc_dt, btn));
      items_sent++;
   endtask

   task automatic wait_for_results(int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_views.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic send_tick();
      send_item(OP_TICK, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
   endtask

   task automatic send_refresh(logic btn);
      send_item(OP_REFRESH, $urandom_range(0, 1), $urandom_range(0, 1), btn);
   endtask

   task automatic send_step(logic clockwise);
      logic enc_clk;
      enc_clk = ~last_clk_q;
      send_item(OP_ENCODER, enc_clk, clockwise ? ~enc_clk : enc_clk, $urandom_range(0, 1));
   endtask

   task automatic adjust_field(int delta, logic btn);
      repeat ((delta < 0) ? -delta : delta) send_step(delta > 0);
      send_refresh(btn);
   endtask

   task automatic return_to_menu();
      send_refresh(1'b0);
      while (mode_q != MODE_MENU) send_refresh(1'b1);
   endtask

   // Expects the menu with a cleared step counter; line 0 opens time, line 1 opens date.
   task automatic enter_mode(logic line);
      adjust_field((menu_q == line) ? 0 : 1, 1'b1);
   endtask

   task automatic set_clock(int hour, int minute, int sec, int pm);
      return_to_menu();
      enter_mode(1'b0);
      adjust_field(hour - hours_q, 1'b1);
      adjust_field(minute - minutes_q, 1'b1);
      adjust_field(sec - seconds_q, 1'b1);
      adjust_field(pm - pm_q, 1'b1);
   endtask

   task automatic set_calendar(int month, int day, int year);
      return_to_menu();
      enter_mode(1'b1);
      adjust_field(month - months_q, 1'b1);
      adjust_field(day - days_q, 1'b1);
      adjust_field(year - years_q, 1'b1);
   endtask

   task automatic test_directed_controls();
      send_tick();
      send_item(2'd3, 1'b1, 1'b1, 1'b1);
      send_item(OP_ENCODER, 1'b0, 1'b1, 1'b0);
      send_item(OP_ENCODER, 1'b1, 1'b0, 1'b0);
      send_item(OP_ENCODER, 1'b0, 1'b0, 1'b1);
      send_step(1'b1);
      send_refresh(1'b0);
      adjust_field(1, 1'b0);
      send_refresh(1'b1);
      send_tick();
      adjust_field(-1, 1'b1);
      adjust_field(-1, 1'b1);
      adjust_field(-1, 1'b1);
      adjust_field(1, 1'b1);
      send_tick();
      send_item(2'd3, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_step_saturation();
      repeat (STEP_MAX + 4) send_step(1'b1);
      send_refresh(1'b0);
      repeat (STEP_MAX + 6) send_step(1'b0);
      send_item(OP_ENCODER, last_clk_q, ~last_clk_q, 1'b0);
      send_refresh(1'b0);
      return_to_menu();
      enter_mode(1'b0);
      repeat (STEP_MAX + 2) send_step(1'b1);
      send_refresh(1'b0);
      return_to_menu();
   endtask

   task automatic test_calendar_rollover();
      set_calendar(1, 31, 2050);
      set_clock(11, 59, 58, 1);
      repeat (3) send_tick();
      set_clock(12, 59, 59, 0);
      send_tick();
      set_calendar(12, 31, 2100);
      set_clock(11, 59, 59, 1);
      repeat (2) send_tick();
      set_calendar(3, 31, 2001);
      enter_mode(1'b1);
      repeat (5) send_tick();
      return_to_menu();
   endtask

   task automatic test_result_backpressure();
      source_idle_on = 1'b0;
      sink_hold_cycles = 200;
      repeat (30)
         send_item($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1));
      wait_for_results(4);
      source_idle_on = 1'b1;
   endtask

   task automatic test_random_sessions();
      int goal;
      int pick;
      int count;
      goal = items_sent + 1000;
      while (items_sent < goal) begin
         if ($urandom_range(0, 39) == 0) source_idle_on = !source_idle_on;
         if ($urandom_range(0, 39) == 0) sink_idle_on = !sink_idle_on;
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            count = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 140)
                                                  : $urandom_range(0, 8);
            repeat (count) begin
               if ($urandom_range(0, 6) == 0)
                  send_item(OP_ENCODER, last_clk_q, $urandom_range(0, 1),
                            $urandom_range(0, 1));
               else
                  send_step($urandom_range(0, 1));
            end
            if ($urandom_range(0, 9) == 0) send_tick();
            send_refresh($urandom_range(0, 2) == 0);
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 8)) send_tick();
         end else if (pick < 78) begin
            set_clock($urandom_range(1, 12), ($urandom_range(0, 1) == 0) ? 59 :
                      $urandom_range(0, 59), $urandom_range(50, 59), $urandom_range(0, 1));
            repeat ($urandom_range(1, 15)) send_tick();
         end else if (pick < 84) begin
            set_calendar($urandom_range(1, 12),
                         ($urandom_range(0, 1) == 0) ? 31 : $urandom_range(1, 31),
                         ($urandom_range(0, 4) == 0) ? 2100 : $urandom_range(2001, 2100));
         end else if (pick < 98) begin
            repeat ($urandom_range(1, 6))
               send_item($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1));
         end else begin
            wait_for_results(4);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_controls();
      test_step_saturation();
      test_calendar_rollover();
      test_result_backpressure();
      test_random_sessions();
      wait_for_results(8);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: clock_calendar_with_encoder_menu.f
rtl/core/ccem_pkg.sv
rtl/core/clock_calendar_with_encoder_menu.sv
rtl/core/ccem_checker.sv
sim/testbench.sv
